FILE: hdl/tspv_pkg.sv
package tspv_pkg;

  localparam int CHAR_W  = 8;
  localparam int POS_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int FIELD_W = 7;
  localparam int QUOT_W  = 8;
  localparam int SUM_W   = 15;
  localparam int DATA_W  = 48;

  // record layout: field boundaries
  localparam logic [POS_W-1:0] POS_YEAR_END   = 5'd4;
  localparam logic [POS_W-1:0] POS_MONTH_END  = 5'd7;
  localparam logic [POS_W-1:0] POS_DAY_END    = 5'd10;
  localparam logic [POS_W-1:0] POS_HOUR_END   = 5'd13;
  localparam logic [POS_W-1:0] POS_MINUTE_END = 5'd16;
  localparam logic [POS_W-1:0] POS_LAST       = 5'd19;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  localparam logic [YEAR_W-1:0] MIN_YEAR         = 14'd1971;
  localparam logic [2:0]        FALLBACK_WEEKDAY = 3'd5;  // 1971-01-01 was a Friday

  // floor(x/25) = (x * DIV25_RECIP) >> DIV25_SHIFT, exact for x < 4096
  localparam logic [17:0] DIV25_RECIP = 18'd167773;
  localparam int          DIV25_SHIFT = 22;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  year_adj;   // year minus one for Jan/Feb
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic               bad;
  } rec_t;

  typedef struct packed {
    logic [2:0]        weekday;
    logic [5:0]        second;
    logic [5:0]        minute;
    logic [4:0]        hour;
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
    logic              ok;
  } res_t;

  // (31*m)/12 with March as month 1
  function automatic logic [4:0] month_offset(input logic [FIELD_W-1:0] mo);
    logic [4:0] r;
    case (mo)
      7'd1:    r = 5'd28;
      7'd2:    r = 5'd31;
      7'd3:    r = 5'd2;
      7'd4:    r = 5'd5;
      7'd5:    r = 5'd7;
      7'd6:    r = 5'd10;
      7'd7:    r = 5'd12;
      7'd8:    r = 5'd15;
      7'd9:    r = 5'd18;
      7'd10:   r = 5'd20;
      7'd11:   r = 5'd23;
      7'd12:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_end(input logic [FIELD_W-1:0] mo, input logic leap);
    logic [4:0] r;
    case (mo)
      7'd4, 7'd6, 7'd9, 7'd11: r = 5'd30;
      7'd2:                    r = leap ? 5'd29 : 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/timestamp_parse_validate.sv
// Timestamp parser/checker for "YYYY-MM-dd hh:mm:ss" records.
// s_axis carries one character per request, 20 characters per record; the
// separator positions are taken without looking at their value.
// m_axis carries one result per record: the parsed date and time with its
// weekday (0 = Sunday) in tdata, and in tuser a flag that is 1 when every
// digit position held a digit and the date/time is legal (year >= 1971).
// Otherwise the result is 1971-01-01 00:00:00 with tuser low.
// Throughput: one character per cycle, sustained; the parser takes a
// character every cycle while tready on m_axis is high.
// After the edge that takes the 20th character, the result passes the record
// register, divide-by-100 stage, check/sum stage and result register in turn
// before it shows on m_axis.
// Reset (rst, synchronous) returns to the first character of a record and
// empties the pipeline. When m_axis stalls, results queue in the pipeline
// stages; s_axis tready drops only once all of them hold a record.
module timestamp_parse_validate (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [13:0] year_out, [17:14] month_out, [22:18] day_out, [27:23] hour_out,
  // [33:28] minute_out, [39:34] second_out, [42:40] weekday_out, [47:43] zero
  output logic [47:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser    // [0] valid_out
);

  localparam int PW = tspv_pkg::POS_W;
  localparam int YW = tspv_pkg::YEAR_W;
  localparam int FW = tspv_pkg::FIELD_W;

  logic [PW-1:0] pos;
  logic          bad;
  logic [YW-1:0] acc;
  logic [YW-1:0] held_year;
  logic [FW-1:0] held_month, held_day, held_hour, held_minute;

  logic          s_fire;
  logic          is_digit;
  logic [YW-1:0] acc_next;
  logic          load_rec;

  tspv_pkg::rec_t rec;
  logic           rec_vld;
  logic           chk_ready;
  tspv_pkg::res_t res;

  assign s_axis_tready = !rec_vld || chk_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign load_rec      = s_fire && (pos == tspv_pkg::POS_LAST);
  assign is_digit      = (s_axis_tdata >= tspv_pkg::CHAR_ZERO) &&
                         (s_axis_tdata <= tspv_pkg::CHAR_NINE);
  // acc*10 + digit, wrapping at the accumulator width
  assign acc_next = (acc << 3) + (acc << 1) +
                    YW'(s_axis_tdata - tspv_pkg::CHAR_ZERO);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      bad         <= 1'b0;
      acc         <= '0;
      held_year   <= '0;
      held_month  <= '0;
      held_day    <= '0;
      held_hour   <= '0;
      held_minute <= '0;
    end else if (s_fire) begin
      if (pos == tspv_pkg::POS_LAST) begin
        pos <= '0;
        bad <= 1'b0;
        acc <= '0;
      end else begin
        pos <= pos + PW'(1);
        if (pos == tspv_pkg::POS_YEAR_END) begin
          held_year <= acc;
          acc       <= '0;
        end else if (pos == tspv_pkg::POS_MONTH_END) begin
          held_month <= acc[FW-1:0];
          acc        <= '0;
        end else if (pos == tspv_pkg::POS_DAY_END) begin
          held_day <= acc[FW-1:0];
          acc      <= '0;
        end else if (pos == tspv_pkg::POS_HOUR_END) begin
          held_hour <= acc[FW-1:0];
          acc       <= '0;
        end else if (pos == tspv_pkg::POS_MINUTE_END) begin
          held_minute <= acc[FW-1:0];
          acc         <= '0;
        end else if (is_digit) begin
          acc <= acc_next;
        end else begin
          bad <= 1'b1;
        end
      end
    end
  end

  // completed record, handed to the checker
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_vld <= 1'b0;
    end else if (s_axis_tready) begin
      rec_vld <= load_rec;
    end
    if (load_rec) begin
      rec.year     <= held_year;
      rec.year_adj <= (held_month <= FW'(2)) ? held_year - YW'(1) : held_year;
      rec.month    <= held_month;
      rec.day      <= held_day;
      rec.hour     <= held_hour;
      rec.minute   <= held_minute;
      rec.second   <= acc[FW-1:0];
      rec.bad      <= bad;
    end
  end

  tspv_check u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rec_vld),
    .in_ready  (chk_ready),
    .in_rec    (rec),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {5'b00000, res.weekday, res.second, res.minute, res.hour,
                         res.day, res.month, res.year};
  assign m_axis_tuser = res.ok;

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= tspv_pkg::POS_LAST)
    else $error("character position past end of record");

  a_rec_loaded: assert property (@(posedge clk) disable iff (rst)
    load_rec |=> rec_vld)
    else $error("20th character did not produce a record");

  a_valid_ranges: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (res.month >= 4'd1 && res.month <= 4'd12 && res.day >= 5'd1 &&
       res.hour <= 5'd23 && res.minute <= 6'd59 && res.second <= 6'd59 &&
       res.weekday <= 3'd6 && res.year >= tspv_pkg::MIN_YEAR))
    else $error("valid result with out-of-range field");

  a_fallback: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (res.year == tspv_pkg::MIN_YEAR && res.month == 4'd1 && res.day == 5'd1 &&
       res.hour == 5'd0 && res.minute == 6'd0 && res.second == 6'd0 &&
       res.weekday == tspv_pkg::FALLBACK_WEEKDAY))
    else $error("rejected record without default timestamp");
`endif

endmodule

FILE: hdl/tspv_check.sv
module tspv_check (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tspv_pkg::rec_t in_rec,
  output logic           out_valid,
  input  logic           out_ready,
  output tspv_pkg::res_t out_res
);

  localparam int QW = tspv_pkg::QUOT_W;
  localparam int SW = tspv_pkg::SUM_W;
  localparam int YW = tspv_pkg::YEAR_W;

  logic en1, en2, en3;
  logic v1, v2, v3;

  tspv_pkg::rec_t s1_rec, s2_rec;
  logic [QW-1:0]  s1_q_y, s1_q_yy;
  logic           s2_ok;
  logic [SW-1:0]  s2_sum;
  tspv_pkg::res_t res;

  logic [29:0]   prod_y, prod_yy;
  logic          leap;
  logic [YW-1:0] y_hundreds;
  logic [4:0]    mend;
  logic          ok_next;
  logic [SW-1:0] sum_next;
  logic [5:0]    fold1;
  logic [3:0]    fold2;
  logic [2:0]    wday;
  tspv_pkg::res_t res_next;

  // each stage moves when empty or when the one after it moves
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // stage 1: hundreds of year and of adjusted year
  assign prod_y  = 30'(in_rec.year[YW-1:2]) * 30'(tspv_pkg::DIV25_RECIP);
  assign prod_yy = 30'(in_rec.year_adj[YW-1:2]) * 30'(tspv_pkg::DIV25_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      s1_rec  <= in_rec;
      s1_q_y  <= prod_y[tspv_pkg::DIV25_SHIFT +: QW];
      s1_q_yy <= prod_yy[tspv_pkg::DIV25_SHIFT +: QW];
    end
  end

  // stage 2: range checks and weekday sum
  always_comb begin
    y_hundreds = YW'({{(YW-QW){1'b0}}, s1_q_y} * YW'(100));
    leap = (s1_rec.year[1:0] == 2'b00) &&
           ((s1_rec.year != y_hundreds) || (s1_q_y[1:0] == 2'b00));
    mend = tspv_pkg::month_end(s1_rec.month, leap);
    ok_next = !s1_rec.bad &&
              (s1_rec.month >= 7'd1) && (s1_rec.month <= 7'd12) &&
              (s1_rec.day >= 7'd1) && (s1_rec.day <= {2'b00, mend}) &&
              (s1_rec.hour <= 7'd23) && (s1_rec.minute <= 7'd59) &&
              (s1_rec.second <= 7'd59) &&
              (s1_rec.year >= tspv_pkg::MIN_YEAR);
    sum_next = SW'(s1_rec.day) + SW'(s1_rec.year_adj) + SW'(s1_rec.year_adj[YW-1:2])
             - SW'(s1_q_yy) + SW'(s1_q_yy[QW-1:2])
             + SW'(tspv_pkg::month_offset(s1_rec.month));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      s2_rec <= s1_rec;
      s2_ok  <= ok_next;
      s2_sum <= sum_next;
    end
  end

  // stage 3: mod 7 by folding octal digits (8 = 1 mod 7), fallback select
  always_comb begin
    fold1 = 6'(s2_sum[2:0]) + 6'(s2_sum[5:3]) + 6'(s2_sum[8:6])
          + 6'(s2_sum[11:9]) + 6'(s2_sum[14:12]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    wday  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    if (s2_ok) begin
      res_next.year    = s2_rec.year;
      res_next.month   = s2_rec.month[3:0];
      res_next.day     = s2_rec.day[4:0];
      res_next.hour    = s2_rec.hour[4:0];
      res_next.minute  = s2_rec.minute[5:0];
      res_next.second  = s2_rec.second[5:0];
      res_next.weekday = wday;
      res_next.ok      = 1'b1;
    end else begin
      res_next.year    = tspv_pkg::MIN_YEAR;
      res_next.month   = 4'd1;
      res_next.day     = 5'd1;
      res_next.hour    = 5'd0;
      res_next.minute  = 6'd0;
      res_next.second  = 6'd0;
      res_next.weekday = tspv_pkg::FALLBACK_WEEKDAY;
      res_next.ok      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      res <= res_next;
    end
  end

  assign out_valid = v3;
  assign out_res   = res;

endmodule

FILE: tb/sv/timestamp_parse_validate_tb.sv
module timestamp_parse_validate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          REC_LEN        = 20;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          TAIL_CYCLES    = 12;
  localparam logic [7:0]  REC_END        = 8'h0A;

  typedef enum int {RX_OPEN, RX_EVERY_THIRD, RX_COIN, RX_CHOKED} rx_mode_t;

  typedef struct {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        ok;
  } stamp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  timestamp_parse_validate dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  // parser state mirror
  logic [4:0]  cur_pos    = '0;
  logic        digit_err  = 1'b0;
  logic [13:0] field_acc  = '0;
  logic [13:0] got_year   = '0;
  logic [6:0]  got_month  = '0;
  logic [6:0]  got_day    = '0;
  logic [6:0]  got_hour   = '0;
  logic [6:0]  got_minute = '0;

  stamp_t      pending_stamps[$];
  logic [7:0]  rec_buf [REC_LEN];
  int          errors = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_left = 0;
  int          rx_count = 0;

  function automatic int month_days(int y, int mo);
    if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
    if (mo == 2) return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
    return 31;
  endfunction

  // Zeller-style weekday, March-based year, 0 = Sunday
  function automatic int weekday_of(int y, int mo, int d);
    int a, yy, mm;
    a  = (14 - mo) / 12;
    yy = y - a;
    mm = mo + 12 * a - 2;
    return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
  endfunction

  function automatic void predict_char(logic [7:0] c);
    stamp_t st;
    int     y, mo, d, h, mi, s;
    logic   good;
    if (cur_pos == tspv_pkg::POS_LAST) begin
      y  = int'(got_year);
      mo = int'(got_month);
      d  = int'(got_day);
      h  = int'(got_hour);
      mi = int'(got_minute);
      s  = int'(field_acc);
      good = !digit_err && mo >= 1 && mo <= 12 && d >= 1 && d <= month_days(y, mo) &&
             h <= 23 && mi <= 59 && s <= 59 && y >= int'(tspv_pkg::MIN_YEAR);
      if (!good) begin
        y = int'(tspv_pkg::MIN_YEAR); mo = 1; d = 1; h = 0; mi = 0; s = 0;
      end
      st.year    = 14'(y);
      st.month   = 4'(mo);
      st.day     = 5'(d);
      st.hour    = 5'(h);
      st.minute  = 6'(mi);
      st.second  = 6'(s);
      st.weekday = 3'(weekday_of(y, mo, d));
      st.ok      = good;
      pending_stamps = {pending_stamps, st};
      cur_pos   = '0;
      digit_err = 1'b0;
      field_acc = '0;
    end else begin
      case (cur_pos)
        tspv_pkg::POS_YEAR_END: begin
          got_year = field_acc; field_acc = '0;
        end
        tspv_pkg::POS_MONTH_END: begin
          got_month = field_acc[6:0]; field_acc = '0;
        end
        tspv_pkg::POS_DAY_END: begin
          got_day = field_acc[6:0]; field_acc = '0;
        end
        tspv_pkg::POS_HOUR_END: begin
          got_hour = field_acc[6:0]; field_acc = '0;
        end
        tspv_pkg::POS_MINUTE_END: begin
          got_minute = field_acc[6:0]; field_acc = '0;
        end
        default: begin
          if (c >= tspv_pkg::CHAR_ZERO && c <= tspv_pkg::CHAR_NINE)
            field_acc = 14'(field_acc * 14'd10 + 14'(c - tspv_pkg::CHAR_ZERO));
          else digit_err = 1'b1;
        end
      endcase
      cur_pos = cur_pos + 1'b1;
    end
  endfunction

  function automatic bit is_sep(int k);
    return k == tspv_pkg::POS_YEAR_END || k == tspv_pkg::POS_MONTH_END ||
           k == tspv_pkg::POS_DAY_END || k == tspv_pkg::POS_HOUR_END ||
           k == tspv_pkg::POS_MINUTE_END || k == tspv_pkg::POS_LAST;
  endfunction

  function automatic void put_digits(int at, int val, int n);
    for (int i = n - 1; i >= 0; i--) begin
      rec_buf[at + i] = 8'(int'(tspv_pkg::CHAR_ZERO) + val % 10);
      val = val / 10;
    end
  endfunction

  function automatic void fill_record(int y, int mo, int d, int h, int mi, int s);
    put_digits(0, y, 4);
    rec_buf[4] = "-";
    put_digits(5, mo, 2);
    rec_buf[7] = "-";
    put_digits(8, d, 2);
    rec_buf[10] = " ";
    put_digits(11, h, 2);
    rec_buf[13] = ":";
    put_digits(14, mi, 2);
    rec_buf[16] = ":";
    put_digits(17, s, 2);
    rec_buf[19] = REC_END;
  endfunction

  // called at a falling edge, returns at the falling edge after the request
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_char(c);
    @(negedge clk);
  endtask

  task automatic send_record();
    for (int i = 0; i < REC_LEN; i++) send_char(rec_buf[i]);
  endtask

  task automatic send_text(input string t, input logic [7:0] term);
    for (int i = 0; i < REC_LEN - 1; i++) send_char(t[i]);
    send_char(term);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (pending_stamps.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) report_mismatch($sformatf("%s: expected %0d, got %0d", name, want, got));
  endtask

  task automatic test_calendar_edges();
    send_text("1971-01-01 00:00:00", REC_END);
    send_text("9999-12-31 23:59:59", REC_END);
    send_text("2000-02-29 12:30:45", REC_END);  // divisible by 400
    send_text("2100-02-29 06:07:08", REC_END);  // century, not leap
    send_text("2023-02-29 10:10:10", REC_END);
    send_text("2023-04-31 01:02:03", REC_END);
  endtask

  task automatic test_range_limits();
    send_text("1970-12-31 23:59:59", REC_END);
    send_text("2023-13-01 00:00:00", REC_END);
    send_text("2023-00-10 00:00:00", REC_END);
    send_text("2023-05-00 00:00:00", REC_END);
    send_text("2023-05-10 24:00:00", REC_END);
    send_text("2023-05-10 23:60:00", REC_END);
    send_text("2023-05-10 23:59:60", REC_END);
  endtask

  task automatic test_odd_chars();
    // any byte passes at a separator, the closing one included
    fill_record(2024, 2, 29, 23, 59, 59);
    for (int i = 0; i < REC_LEN; i++)
      if (is_sep(i)) rec_buf[i] = (i == tspv_pkg::POS_LAST) ? 8'h00 : 8'hFF;
    send_record();
    fill_record(2024, 2, 29, 23, 59, 59);
    rec_buf[0] = tspv_pkg::CHAR_ZERO - 8'd1;
    send_record();
    fill_record(2024, 2, 29, 23, 59, 59);
    rec_buf[18] = tspv_pkg::CHAR_NINE + 8'd1;
    send_record();
  endtask

  task automatic test_pause_for_drain();
    fill_record(2038, 1, 19, 3, 14, 7);
    send_record();
    wait_drained();
    send_text("2038-01-19 03:14:08", REC_END);
    wait_drained();
  endtask

  task automatic test_random_records(input int count);
    int         y, mo, d, h, mi, s, kind, k;
    logic [7:0] c;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      y  = ($urandom_range(0, 3) == 0) ? $urandom_range(1971, 9999) : $urandom_range(1971, 2130);
      mo = $urandom_range(1, 12);
      d  = $urandom_range(1, month_days(y, mo));
      h  = $urandom_range(0, 23);
      mi = $urandom_range(0, 59);
      s  = $urandom_range(0, 59);
      if (kind >= 60 && kind < 72) begin
        case ($urandom_range(0, 5))
          0: y = $urandom_range(0, 1970);
          1: mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
          2: d = $urandom_range(0, 1) ? 0 : $urandom_range(month_days(y, mo) + 1, 99);
          3: h = $urandom_range(24, 99);
          4: mi = $urandom_range(60, 99);
          default: s = $urandom_range(60, 99);
        endcase
      end else if (kind >= 72 && kind < 84) begin
        // end of February, leap and century years
        mo = 2;
        d  = $urandom_range(28, 29);
        y  = $urandom_range(0, 1) ? 4 * $urandom_range(493, 2499) : 100 * $urandom_range(20, 99);
      end
      fill_record(y, mo, d, h, mi, s);
      if (kind >= 84 && kind < 94) begin
        do k = $urandom_range(0, REC_LEN - 2); while (is_sep(k));
        do c = 8'($urandom_range(0, 255));
        while (c >= tspv_pkg::CHAR_ZERO && c <= tspv_pkg::CHAR_NINE);
        rec_buf[k] = c;
      end else if (kind >= 94) begin
        for (int i = 0; i < REC_LEN; i++) rec_buf[i] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < REC_LEN; i++) if (is_sep(i)) rec_buf[i] = 8'($urandom_range(0, 255));
      send_record();
      if (n % 13 == 12) wait_drained();
    end
  endtask

  // receiver backpressure, pattern changes every so often
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_count++;
    case (rx_mode)
      RX_OPEN:        m_axis_tready = 1'b1;
      RX_EVERY_THIRD: m_axis_tready = (rx_count % 3) != 0;
      RX_COIN:        m_axis_tready = ($urandom_range(0, 1) == 1);
      default:        m_axis_tready = ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    stamp_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_stamps.size() == 0) begin
        report_mismatch($sformatf("result with none pending, tdata %h", m_axis_tdata));
      end else begin
        want = pending_stamps.pop_front();
        check_field("year",    int'(want.year),    int'(m_axis_tdata[13:0]));
        check_field("month",   int'(want.month),   int'(m_axis_tdata[17:14]));
        check_field("day",     int'(want.day),     int'(m_axis_tdata[22:18]));
        check_field("hour",    int'(want.hour),    int'(m_axis_tdata[27:23]));
        check_field("minute",  int'(want.minute),  int'(m_axis_tdata[33:28]));
        check_field("second",  int'(want.second),  int'(m_axis_tdata[39:34]));
        check_field("weekday", int'(want.weekday), int'(m_axis_tdata[42:40]));
        check_field("pad",     0,                  int'(m_axis_tdata[47:43]));
        check_field("valid",   int'(want.ok),      int'(m_axis_tuser[0]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_calendar_edges();
    test_range_limits();
    test_odd_chars();
    test_pause_for_drain();
    test_random_records(37);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: timestamp_parse_validate.f
hdl/tspv_pkg.sv
hdl/tspv_check.sv
hdl/timestamp_parse_validate.sv
tb/sv/timestamp_parse_validate_tb.sv
